### rtl/ssd_pkg.sv
// Shared types, codes and constants for the two-wire seven-segment driver.
// No dependencies; all rtl files but ssd_queue use it by scoped names.
package ssd_pkg;

    localparam int DIGITS_DEF  = 4;
    localparam int QUEUE_DEPTH = 4;

    // Item kinds carried on s_tuser
    localparam logic OP_SHOW = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [2:0] BRIGHT_RESET = 3'd3;

    // Command bytes of the display protocol
    localparam logic [7:0] CMD_DATA  = 8'h40 | 8'h04;
    localparam logic [7:0] ADDR_BASE = 8'hC0;
    localparam logic [7:0] ADDR_MASK = 8'h3F;
    localparam logic [7:0] DISP_ON   = 8'h88;

    // x / 10 == (x * RECIP) >> RECIP_SHIFT for every 16-bit x
    localparam logic [16:0] RECIP       = 17'h0CCCD;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_BITS  = 3'd2,
        PH_ACK   = 3'd3,
        PH_STOP  = 3'd4,
        PH_TAIL  = 3'd5
    } phase_t;

    // Frames sent for one digit
    typedef enum logic [1:0] {
        FR_CMD        = 2'd0,
        FR_ADDR       = 2'd1,
        FR_PATTERN    = 2'd2,
        FR_DISPLAY_ON = 2'd3
    } frame_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        unique case (digit)
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = 8'h3F;
        endcase
        return pat;
    endfunction

endpackage

### rtl/ssd_front.sv
// Front end: accepts input words and splits the number into decimal digits,
// one digit per pipeline stage. Depends on ssd_pkg.
module ssd_front #(
    parameter int DIGITS = ssd_pkg::DIGITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    in_op,
    input  logic [15:0]             in_number,
    input  logic                    in_dio,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_op,
    output logic                    out_dio,
    output logic [DIGITS-1:0][3:0]  out_digits
);

    logic                   vld_reg  [0:DIGITS];
    logic                   op_reg   [0:DIGITS];
    logic                   dio_reg  [0:DIGITS];
    logic [15:0]            quot_reg [0:DIGITS];
    logic [DIGITS-1:0][3:0] dig_reg  [0:DIGITS];
    logic                   advance;

    // Stall the whole pipe only when the last stage holds a word the queue refuses
    assign advance  = !vld_reg[DIGITS] || out_ready;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (advance) begin
            vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            op_reg[0]   <= in_op;
            dio_reg[0]  <= in_dio;
            quot_reg[0] <= in_number;
            dig_reg[0]  <= '0;
        end
    end

    for (genvar i = 1; i <= DIGITS; i++) begin : g_stage
        logic [32:0]            prod;
        logic [15:0]            quot_next;
        logic [15:0]            rem;
        logic [DIGITS-1:0][3:0] dig_next;

        assign prod      = {1'b0, quot_reg[i-1]} * {16'd0, ssd_pkg::RECIP};
        assign quot_next = {2'b00, prod[32:ssd_pkg::RECIP_SHIFT]};
        assign rem       = quot_reg[i-1] - ((quot_next << 3) + (quot_next << 1));

        always_comb begin
            dig_next      = dig_reg[i-1];
            dig_next[i-1] = rem[3:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (advance) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                op_reg[i]   <= op_reg[i-1];
                dio_reg[i]  <= dio_reg[i-1];
                quot_reg[i] <= quot_next;
                dig_reg[i]  <= dig_next;
            end
        end
    end

    assign out_valid  = vld_reg[DIGITS];
    assign out_op     = op_reg[DIGITS];
    assign out_dio    = dio_reg[DIGITS];
    assign out_digits = dig_reg[DIGITS];

endmodule

### rtl/ssd_queue.sv
// Short word queue between the digit splitter and the waveform engine.
// Flop storage, first word always visible at the head. Depends on nothing.
module ssd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/ssd_back.sv
// Back end: loads digits on a show word, steps the two-wire waveform a step
// per tick word, holds the result word in an output register. Uses ssd_pkg.
module ssd_back #(
    parameter int DIGITS = ssd_pkg::DIGITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [2:0]              brightness,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    in_op,
    input  logic                    in_dio,
    input  logic [DIGITS-1:0][3:0]  in_digits,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata
);

    localparam int POS_W = $clog2(DIGITS + 1);
    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    ssd_pkg::phase_t        phase_reg, phase_next;
    logic [3:0]             cnt_reg, cnt_next;
    ssd_pkg::frame_t        step_reg, step_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   clk_pin_reg, clk_pin_next;
    logic                   dio_pin_reg, dio_pin_next;
    logic                   drv_pin_reg, drv_pin_next;
    logic                   ack_reg, ack_next;
    logic [DIGITS-1:0][3:0] digits_reg, digits_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [7:0]             m_tdata_reg, m_tdata_next;

    logic                   take, do_show, do_tick;
    logic [POS_W-1:0]       pos_inc;
    logic [3:0]             cur_digit;
    logic [7:0]             cur_addr;

    // A show word never makes a result, so it may pass a stalled output
    assign in_ready = (in_op == ssd_pkg::OP_SHOW) || !m_tvalid_reg || m_tready;
    assign take     = in_valid && in_ready;
    assign do_show  = take && (in_op == ssd_pkg::OP_SHOW);
    assign do_tick  = take && (in_op == ssd_pkg::OP_TICK);

    assign pos_inc   = pos_reg + 1'b1;
    assign cur_digit = (pos_reg < POS_W'(DIGITS)) ? digits_reg[pos_reg[IDX_W-1:0]] : 4'd0;
    assign cur_addr  = ssd_pkg::ADDR_BASE
                     | ((8'(DIGITS - 1) - 8'(pos_reg)) & ssd_pkg::ADDR_MASK);

    always_comb begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        step_next     = step_reg;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        clk_pin_next  = clk_pin_reg;
        dio_pin_next  = dio_pin_reg;
        drv_pin_next  = drv_pin_reg;
        ack_next      = ack_reg;
        digits_next   = digits_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (do_show) begin
            // drop a show that arrives while a sequence is running
            if (phase_reg == ssd_pkg::PH_IDLE) begin
                digits_next = in_digits;
                pos_next    = '0;
                step_next   = ssd_pkg::FR_CMD;
                cnt_next    = 4'd0;
                shift_next  = ssd_pkg::CMD_DATA;
                phase_next  = ssd_pkg::PH_START;
            end
        end else if (do_tick) begin
            unique case (phase_reg)
                ssd_pkg::PH_START: begin
                    clk_pin_next = 1'b1;
                    dio_pin_next = 1'b1;
                    drv_pin_next = 1'b1;
                    phase_next   = ssd_pkg::PH_BITS;
                    cnt_next     = 4'd0;
                end
                ssd_pkg::PH_BITS: begin
                    if (!cnt_reg[0]) begin
                        // the start condition's falling data edge lands here
                        if (cnt_reg == 4'd0 && step_reg != ssd_pkg::FR_PATTERN) begin
                            dio_pin_next = 1'b0;
                        end
                        drv_pin_next = 1'b1;
                        clk_pin_next = 1'b0;
                    end else begin
                        dio_pin_next = shift_reg[0];
                        clk_pin_next = 1'b1;
                        shift_next   = shift_reg >> 1;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 4'd15) begin
                        phase_next = ssd_pkg::PH_ACK;
                        cnt_next   = 4'd0;
                    end
                end
                ssd_pkg::PH_ACK: begin
                    if (cnt_reg == 4'd0) begin
                        clk_pin_next = 1'b0;
                        drv_pin_next = 1'b0;
                        dio_pin_next = 1'b1;
                        cnt_next     = 4'd1;
                    end else if (cnt_reg == 4'd1) begin
                        ack_next = in_dio;
                        if (in_dio) begin
                            drv_pin_next = 1'b1;
                            dio_pin_next = 1'b0;
                        end
                        cnt_next = 4'd2;
                    end else begin
                        clk_pin_next = 1'b1;
                        cnt_next     = 4'd0;
                        if (step_reg == ssd_pkg::FR_ADDR) begin
                            step_next  = ssd_pkg::FR_PATTERN;
                            shift_next = ssd_pkg::seg_pattern(cur_digit);
                            phase_next = ssd_pkg::PH_BITS;
                        end else begin
                            phase_next = ssd_pkg::PH_STOP;
                        end
                    end
                end
                ssd_pkg::PH_STOP: begin
                    if (cnt_reg == 4'd0) begin
                        clk_pin_next = 1'b0;
                        drv_pin_next = 1'b1;
                        cnt_next     = 4'd1;
                    end else if (cnt_reg == 4'd1) begin
                        dio_pin_next = 1'b0;
                        cnt_next     = 4'd2;
                    end else begin
                        clk_pin_next = 1'b1;
                        cnt_next     = 4'd0;
                        if (step_reg == ssd_pkg::FR_CMD) begin
                            step_next  = ssd_pkg::FR_ADDR;
                            shift_next = cur_addr;
                            phase_next = ssd_pkg::PH_START;
                        end else if (step_reg == ssd_pkg::FR_PATTERN) begin
                            step_next  = ssd_pkg::FR_DISPLAY_ON;
                            shift_next = ssd_pkg::DISP_ON | {5'd0, brightness};
                            phase_next = ssd_pkg::PH_START;
                        end else begin
                            pos_next = pos_inc;
                            if (pos_inc < POS_W'(DIGITS)) begin
                                step_next  = ssd_pkg::FR_CMD;
                                shift_next = ssd_pkg::CMD_DATA;
                                phase_next = ssd_pkg::PH_START;
                            end else begin
                                phase_next = ssd_pkg::PH_TAIL;
                            end
                        end
                    end
                end
                ssd_pkg::PH_TAIL: begin
                    dio_pin_next = 1'b1;
                    drv_pin_next = 1'b1;
                    phase_next   = ssd_pkg::PH_IDLE;
                end
                default: begin
                    phase_next = ssd_pkg::PH_IDLE;
                end
            endcase

            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'd0, ack_next, (phase_next != ssd_pkg::PH_IDLE),
                             drv_pin_next, dio_pin_next, clk_pin_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= ssd_pkg::PH_IDLE;
            cnt_reg      <= 4'd0;
            step_reg     <= ssd_pkg::FR_CMD;
            pos_reg      <= '0;
            shift_reg    <= 8'd0;
            clk_pin_reg  <= 1'b1;
            dio_pin_reg  <= 1'b1;
            drv_pin_reg  <= 1'b1;
            ack_reg      <= 1'b0;
            digits_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            step_reg     <= step_next;
            pos_reg      <= pos_next;
            shift_reg    <= shift_next;
            clk_pin_reg  <= clk_pin_next;
            dio_pin_reg  <= dio_pin_next;
            drv_pin_reg  <= drv_pin_next;
            ack_reg      <= ack_next;
            digits_reg   <= digits_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // data is released only inside an acknowledge or right after one
    a_release_window: assert property (@(posedge aclk) disable iff (!aresetn)
        !drv_pin_reg |-> (phase_reg == ssd_pkg::PH_ACK)
            || (cnt_reg == 4'd0
                && (phase_reg == ssd_pkg::PH_BITS || phase_reg == ssd_pkg::PH_STOP)))
        else $error("data pin released outside acknowledge window");

    a_show_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_show && phase_reg == ssd_pkg::PH_IDLE) |=> phase_reg == ssd_pkg::PH_START)
        else $error("show while idle did not start a sequence");

    a_sub_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == ssd_pkg::PH_ACK || phase_reg == ssd_pkg::PH_STOP) |-> cnt_reg <= 4'd2)
        else $error("acknowledge or stop sub-step out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("pending result word was overwritten");
`endif

endmodule

### rtl/seven_segment_two_wire_driver.sv
// Top level of the two-wire four-digit seven-segment driver: brightness
// register, digit splitter, word queue and waveform engine.
// Depends on ssd_pkg, ssd_front, ssd_queue and ssd_back.

// Takes one input word per clock while s_tready is high. A show word
// (s_tuser = 0) loads the DIGITS lowest decimal digits of the number and
// starts a display sequence unless one is already running, in which case it
// is dropped; it gives no result. A tick word (s_tuser = 1) stands for one
// half-bit wait on the display bus, advances the waveform one step and gives
// exactly one result word with the pin levels, the busy flag and the last
// acknowledge sample. Words pass a digit-splitting pipeline of DIGITS + 1
// register stages (one reciprocal multiply per digit), a QUEUE_DEPTH-word
// queue and the output register. Brightness is written through the cfg port
// and is sampled when the display-on command is loaded; write it only while
// the block is idle.
module seven_segment_two_wire_driver #(
    parameter int DIGITS      = ssd_pkg::DIGITS_DEF,
    parameter int QUEUE_DEPTH = ssd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] number, [16] dio_in, [23:17] zero
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] clk_level, [1] dio_level, [2] dio_drive,
                                   // [3] busy_res, [4] ack_missing, [7:5] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);

    localparam int ENTRY_W = 2 + 4 * DIGITS;

    logic [2:0]             brightness_reg;
    logic                   fr_valid, fr_ready, fr_op, fr_dio;
    logic [DIGITS-1:0][3:0] fr_digits;
    logic                   q_valid, q_ready;
    logic [ENTRY_W-1:0]     q_data;
    logic [DIGITS-1:0][3:0] q_digits;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= ssd_pkg::BRIGHT_RESET;
        end else if (cfg_valid) begin
            brightness_reg <= cfg_data;
        end
    end

    ssd_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_op      (s_tuser),
        .in_number  (s_tdata[15:0]),
        .in_dio     (s_tdata[16]),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .out_op     (fr_op),
        .out_dio    (fr_dio),
        .out_digits (fr_digits)
    );

    ssd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  ({fr_digits, fr_dio, fr_op}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign q_digits = q_data[ENTRY_W-1:2];

    ssd_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .brightness (brightness_reg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_op      (q_data[0]),
        .in_dio     (q_data[1]),
        .in_digits  (q_digits),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### test/tb_seven_segment_two_wire_driver.sv
`timescale 1ns / 1ps
// Self-checking testbench for seven_segment_two_wire_driver: random show and tick words
// against a cycle-free model of the two-wire display waveform. Depends on ssd_pkg and the RTL.
module tb_seven_segment_two_wire_driver;

    localparam int CLK_PERIOD     = 8;
    localparam int DIGITS         = ssd_pkg::DIGITS_DEF;
    localparam int DRAIN_CYCLES   = 4 * (DIGITS + 3) + 4 * ssd_pkg::QUEUE_DEPTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PER_SET = 225;

    typedef struct {
        logic        op;
        logic [15:0] number;
        logic        dio_in;
    } disp_item_t;

    // Packs like m_tdata[4:0]: first member is the top bit
    typedef struct packed {
        logic ack_missing;
        logic busy;
        logic dio_drive;
        logic dio_level;
        logic clk_level;
    } pin_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_data  = '0;

    seven_segment_two_wire_driver u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    disp_item_t item_q[$];
    pin_word_t  pins_expected[$];

    int errors           = 0;
    int ticks_taken      = 0;
    int shows_taken      = 0;
    int shows_dropped    = 0;
    int sequences_done   = 0;
    int results_checked  = 0;
    int ack_missing_seen = 0;
    int idle_cycles      = 0;
    int last_brightness  = 0;

    // Display model state
    logic [3:0]      disp_digits [DIGITS];
    int              disp_pos;
    ssd_pkg::frame_t disp_frame;
    ssd_pkg::phase_t disp_phase;
    int              disp_bit_cnt;
    logic [7:0]      disp_shift;
    logic            pin_clk;
    logic            pin_dio;
    logic            pin_drive;
    logic            ack_seen_high;
    logic [2:0]      disp_brightness;

    logic [7:0] seg_lut [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic reset_display_model();
        int i;
        for (i = 0; i < DIGITS; i++) begin
            disp_digits[i] = '0;
        end
        disp_pos        = 0;
        disp_frame      = ssd_pkg::FR_CMD;
        disp_phase      = ssd_pkg::PH_IDLE;
        disp_bit_cnt    = 0;
        disp_shift      = '0;
        pin_clk         = 1'b1;
        pin_dio         = 1'b1;
        pin_drive       = 1'b1;
        ack_seen_high   = 1'b0;
        disp_brightness = ssd_pkg::BRIGHT_RESET;
    endtask

    // One tick: apply pin changes up to the next half-bit wait
    task automatic advance_waveform(input logic dio_in);
        case (disp_phase)
            ssd_pkg::PH_START: begin
                pin_clk      = 1'b1;
                pin_dio      = 1'b1;
                pin_drive    = 1'b1;
                disp_phase   = ssd_pkg::PH_BITS;
                disp_bit_cnt = 0;
            end
            ssd_pkg::PH_BITS: begin
                if (disp_bit_cnt % 2 == 0) begin
                    // start condition: data falls on the first clock-low step
                    if (disp_bit_cnt == 0 && disp_frame != ssd_pkg::FR_PATTERN) pin_dio = 1'b0;
                    pin_drive = 1'b1;
                    pin_clk   = 1'b0;
                end else begin
                    pin_dio    = disp_shift[0];
                    pin_clk    = 1'b1;
                    disp_shift = disp_shift >> 1;
                end
                disp_bit_cnt++;
                if (disp_bit_cnt >= 16) begin
                    disp_phase   = ssd_pkg::PH_ACK;
                    disp_bit_cnt = 0;
                end
            end
            ssd_pkg::PH_ACK: begin
                if (disp_bit_cnt == 0) begin
                    pin_clk      = 1'b0;
                    pin_drive    = 1'b0;
                    pin_dio      = 1'b1;
                    disp_bit_cnt = 1;
                end else if (disp_bit_cnt == 1) begin
                    ack_seen_high = dio_in;
                    if (dio_in) begin
                        pin_drive = 1'b1;
                        pin_dio   = 1'b0;
                    end
                    disp_bit_cnt = 2;
                end else begin
                    pin_clk      = 1'b1;
                    disp_bit_cnt = 0;
                    if (disp_frame == ssd_pkg::FR_ADDR) begin
                        disp_frame = ssd_pkg::FR_PATTERN;
                        disp_shift = seg_lut[disp_digits[disp_pos]];
                        disp_phase = ssd_pkg::PH_BITS;
                    end else begin
                        disp_phase = ssd_pkg::PH_STOP;
                    end
                end
            end
            ssd_pkg::PH_STOP: begin
                if (disp_bit_cnt == 0) begin
                    pin_clk      = 1'b0;
                    pin_drive    = 1'b1;
                    disp_bit_cnt = 1;
                end else if (disp_bit_cnt == 1) begin
                    pin_dio      = 1'b0;
                    disp_bit_cnt = 2;
                end else begin
                    pin_clk      = 1'b1;
                    disp_bit_cnt = 0;
                    if (disp_frame == ssd_pkg::FR_CMD) begin
                        disp_frame = ssd_pkg::FR_ADDR;
                        disp_shift = ssd_pkg::ADDR_BASE
                                   | (8'(DIGITS - 1 - disp_pos) & ssd_pkg::ADDR_MASK);
                        disp_phase = ssd_pkg::PH_START;
                    end else if (disp_frame == ssd_pkg::FR_PATTERN) begin
                        disp_frame = ssd_pkg::FR_DISPLAY_ON;
                        disp_shift = ssd_pkg::DISP_ON | {5'b0, disp_brightness};
                        disp_phase = ssd_pkg::PH_START;
                    end else begin
                        disp_pos++;
                        if (disp_pos < DIGITS) begin
                            disp_frame = ssd_pkg::FR_CMD;
                            disp_shift = ssd_pkg::CMD_DATA;
                            disp_phase = ssd_pkg::PH_START;
                        end else begin
                            disp_phase = ssd_pkg::PH_TAIL;
                        end
                    end
                end
            end
            ssd_pkg::PH_TAIL: begin
                pin_dio    = 1'b1;
                pin_drive  = 1'b1;
                disp_phase = ssd_pkg::PH_IDLE;
                sequences_done++;
            end
            default: disp_phase = ssd_pkg::PH_IDLE;
        endcase
    endtask

    task automatic predict_display(input disp_item_t it);
        pin_word_t   w;
        logic [15:0] rest;
        int          i;
        if (it.op == ssd_pkg::OP_SHOW) begin
            shows_taken++;
            if (disp_phase != ssd_pkg::PH_IDLE) begin
                shows_dropped++;
            end else begin
                rest = it.number;
                for (i = 0; i < DIGITS; i++) begin
                    disp_digits[i] = 4'(rest % 16'd10);
                    rest           = rest / 16'd10;
                end
                disp_pos     = 0;
                disp_frame   = ssd_pkg::FR_CMD;
                disp_bit_cnt = 0;
                disp_shift   = ssd_pkg::CMD_DATA;
                disp_phase   = ssd_pkg::PH_START;
            end
        end else begin
            ticks_taken++;
            advance_waveform(it.dio_in);
            w.clk_level   = pin_clk;
            w.dio_level   = pin_dio;
            w.dio_drive   = pin_drive;
            w.busy        = (disp_phase != ssd_pkg::PH_IDLE);
            w.ack_missing = ack_seen_high;
            pins_expected.push_back(w);
        end
    endtask

    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        // now and then a run of back-to-back words
        if ($urandom_range(0, 39) == 0) run_left = $urandom_range(20, 80);
        return $urandom_range(0, 10);
    endfunction

    // Driver
    logic s_taken = 1'b0;
    logic m_taken = 1'b0;
    int   send_gap = -1;
    int   send_run = 0;
    int   stall_left = -1;
    int   stall_run = 0;

    always @(negedge aclk) begin
        disp_item_t it;
        logic       next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = -1;
        end else if (!s_tvalid || s_taken) begin
            next_valid = 1'b0;
            if (item_q.size() != 0) begin
                if (send_gap < 0) send_gap = draw_wait(send_run);
                if (send_gap == 0) begin
                    it = item_q.pop_front();
                    s_tdata    <= {7'b0, it.dio_in, it.number};
                    s_tuser    <= it.op;
                    next_valid = 1'b1;
                    send_gap   = -1;
                end else begin
                    send_gap--;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Result-side back-pressure: one stall length per word
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = -1;
        end else begin
            if (m_taken || stall_left < 0) stall_left = draw_wait(stall_run);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor, model and watchdog
    always @(posedge aclk) begin
        disp_item_t it;
        pin_word_t  got;
        pin_word_t  want;
        s_taken <= aresetn && s_tvalid && s_tready;
        m_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            idle_cycles++;
            if (cfg_valid && cfg_ready) begin
                disp_brightness = cfg_data;
                idle_cycles     = 0;
            end
            if (s_tvalid && s_tready) begin
                it.op     = s_tuser;
                it.number = s_tdata[15:0];
                it.dio_in = s_tdata[16];
                predict_display(it);
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                got = m_tdata[4:0];
                if (pins_expected.size() == 0) begin
                    report_mismatch("unexpected result word", int'(m_tdata), 0);
                end else begin
                    want = pins_expected.pop_front();
                    results_checked++;
                    if (got.ack_missing) ack_missing_seen++;
                    if (got.clk_level !== want.clk_level)
                        report_mismatch("clk_level", int'(got.clk_level),
                                        int'(want.clk_level));
                    if (got.dio_level !== want.dio_level)
                        report_mismatch("dio_level", int'(got.dio_level),
                                        int'(want.dio_level));
                    if (got.dio_drive !== want.dio_drive)
                        report_mismatch("dio_drive", int'(got.dio_drive),
                                        int'(want.dio_drive));
                    if (got.busy !== want.busy)
                        report_mismatch("busy", int'(got.busy), int'(want.busy));
                    if (got.ack_missing !== want.ack_missing)
                        report_mismatch("ack_missing", int'(got.ack_missing),
                                        int'(want.ack_missing));
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no word moved for %0d cycles", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic push_item(input logic op, input logic [15:0] number, input logic dio_in);
        disp_item_t it;
        it.op     = op;
        it.number = number;
        it.dio_in = dio_in;
        item_q.push_back(it);
    endtask

    task automatic queue_random_items(input int count);
        logic [15:0] number;
        int          n;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(0, 15))
                0:       number = 16'd0;
                1:       number = 16'd9999;
                2:       number = 16'd10000;
                3:       number = 16'hFFFF;
                4:       number = 16'd8888;
                default: number = 16'($urandom_range(0, 16'hFFFF));
            endcase
            // mostly acknowledged; a missing acknowledge now and then
            push_item(($urandom_range(0, 24) == 0) ? ssd_pkg::OP_SHOW : ssd_pkg::OP_TICK,
                      number, ($urandom_range(0, 3) == 0));
        end
    endtask

    task automatic wait_until_drained();
        while (item_q.size() != 0 || s_tvalid || pins_expected.size() != 0) begin
            @(posedge aclk);
        end
        // shows give no result and may still sit in the pipeline
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_brightness(input logic [2:0] level);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= level;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        last_brightness = int'(level);
    endtask

    initial begin
        int k;
        reset_display_model();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: idle ticks, a show beyond four digits, a show while busy,
        // then the first frame with its acknowledge left high
        push_item(ssd_pkg::OP_TICK, 16'd0, 1'b0);
        push_item(ssd_pkg::OP_TICK, 16'hFFFF, 1'b1);
        push_item(ssd_pkg::OP_SHOW, 16'hFFFF, 1'b0);
        push_item(ssd_pkg::OP_SHOW, 16'd12345, 1'b1);
        for (k = 0; k < 20; k++) begin
            push_item(ssd_pkg::OP_TICK, k[15:0], (k == 18));
        end
        queue_random_items(RANDOM_PER_SET);
        wait_until_drained();

        write_brightness(3'd7);
        queue_random_items(RANDOM_PER_SET);
        wait_until_drained();

        write_brightness(3'd0);
        queue_random_items(RANDOM_PER_SET);
        wait_until_drained();

        write_brightness(3'($urandom_range(1, 6)));
        queue_random_items(RANDOM_PER_SET);
        wait_until_drained();

        if (pins_expected.size() != 0)
            report_mismatch("result words never seen", 0, pins_expected.size());

        $display("Run covered %0d tick and %0d show words (%0d dropped while busy)",
                 ticks_taken, shows_taken, shows_dropped);
        $display("%0d full sequences, %0d results checked, %0d with ack missing, brightness %0d",
                 sequences_done, results_checked, ack_missing_seen, last_brightness);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ssd_pkg.sv
rtl/ssd_front.sv
rtl/ssd_queue.sv
rtl/ssd_back.sv
rtl/seven_segment_two_wire_driver.sv
test/tb_seven_segment_two_wire_driver.sv
